### sv/scg_pkg.sv
package scg_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 512;
    localparam int WALK_DEPTH = MAX_NODES + MAX_EDGES;

    localparam int NODE_W  = 6;
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int WALK_AW = $clog2(WALK_DEPTH);
    localparam int WSP_W   = $clog2(WALK_DEPTH + 1);
    localparam int FIN_AW  = $clog2(MAX_NODES);
    localparam int EDGE_W  = 2 * NODE_W;
    localparam int WALK_W  = NODE_W + 1;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_USE_MASK   = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD_EDGE   = 2'd0,
        ACT_SET_ACTIVE = 2'd1,
        ACT_RUN        = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic                active_flag;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0]   node_index;
        logic [NODE_W-1:0]   group_index;
        logic                assigned;
        logic [NODE_W-1:0]   minimum_group;
        logic                minimum_found;
        logic                edges_overflowed;
        logic                last;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P1_NODE,
        S_P1_NEXT,
        S_P1_POP,
        S_P1_POPW,
        S_P1_SCAN,
        S_P1_SCANW,
        S_P2_FIN,
        S_P2_FINW,
        S_P2_POP,
        S_P2_POPW,
        S_P2_SCAN,
        S_P2_SCANW,
        S_M_NODE,
        S_M_NODEW,
        S_M_SCAN,
        S_M_SCANW,
        S_M_PREDW,
        S_O_READ,
        S_O_EMIT
    } t_state;

endpackage

### sv/scg_ram.sv
module scg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/strongly_connected_groups.sv
// Channel   Direction  Handshake                         Payload
// request   in         start && !busy                    i_req (t_req)
// result    out        o_res_strobe, one cycle, no stall o_res (t_res)
// config    in         psel && penable && pwrite         pwdata at paddr 0, 4
//
// Add edge, set active and clear are done in idle; busy stays low.
// A run walks every stored edge for every node visited in both passes; in mask mode
// the minimum group search scans edges for group members, with a group read where a
// predecessor is an active node; then one result per node. Each memory read is
// registered, so its data is used in the state that follows the read.
// Reset is synchronous, active low; results cannot be stalled by the receiver.
module strongly_connected_groups
    import scg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_res_strobe,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_node_count, n_node_count;
    logic                 r_use_mask, n_use_mask;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [NODE_W-1:0]    r_v, n_v;
    logic [CNT_W-1:0]     r_mv, n_mv;
    logic [WSP_W-1:0]     r_sp, n_sp;
    logic [CNT_W-1:0]     r_fc, n_fc;
    logic [ECNT_W-1:0]    r_i, n_i;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_f, n_f;
    logic [NODE_W-1:0]    r_gi, n_gi;
    logic [CNT_W-1:0]     r_groups, n_groups;
    logic                 r_minf, n_minf;
    logic [NODE_W-1:0]    r_ming, n_ming;
    logic [MAX_NODES-1:0] r_vis1, n_vis1;
    logic [MAX_NODES-1:0] r_asg, n_asg;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic [ECNT_W-1:0]    r_ecnt, n_ecnt;
    logic                 r_ovf, n_ovf;
    t_res                 r_res, n_res;
    logic                 r_strobe, n_strobe;

    logic                 es_we, es_re;
    logic [EDGE_AW-1:0]   es_waddr, es_raddr;
    logic [EDGE_W-1:0]    es_wdata, es_rdata;
    logic                 ws_we, ws_re;
    logic [WALK_AW-1:0]   ws_waddr, ws_raddr;
    logic [WALK_W-1:0]    ws_wdata, ws_rdata;
    logic                 fs_we, fs_re;
    logic [FIN_AW-1:0]    fs_waddr, fs_raddr;
    logic [NODE_W-1:0]    fs_wdata, fs_rdata;
    logic                 gs_we, gs_re;
    logic [FIN_AW-1:0]    gs_waddr, gs_raddr;
    logic [NODE_W-1:0]    gs_wdata, gs_rdata;

    logic                 accept, cfg_wr;
    logic [CNT_W-1:0]     n_eff;
    logic [NODE_W-1:0]    ef, et, wcur;
    logic                 ws_room, edges_done;
    logic                 hit1, hit2, pred_cand, v_free;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = (r_state != S_IDLE);
    assign prdata = (paddr[2] == REG_USE_MASK) ? {31'd0, r_use_mask}
                                               : {{(32-CNT_W){1'b0}}, r_node_count};

    assign n_eff = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign ef    = es_rdata[EDGE_W-1:NODE_W];
    assign et    = es_rdata[NODE_W-1:0];
    assign wcur  = ws_rdata[NODE_W-1:0];
    assign ws_room    = (r_sp < WSP_W'(WALK_DEPTH));
    assign edges_done = (r_i == r_ecnt);
    assign v_free = (!r_use_mask || r_mask[r_v]) && !r_vis1[r_v];
    assign hit1 = (ef == r_cur) && ({1'b0, et} < r_n) && (!r_use_mask || r_mask[et])
                  && !r_vis1[et] && ws_room;
    assign hit2 = (et == r_cur) && ({1'b0, ef} < r_n) && (!r_use_mask || r_mask[ef])
                  && !r_asg[ef] && ws_room;
    assign pred_cand = (et == r_mv[NODE_W-1:0]) && ({1'b0, ef} < r_n) && r_mask[ef];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req.action == ACT_RUN && n_eff != '0) begin
                    n_state = S_P1_NODE;
                end
            end
            S_P1_NODE:  n_state = v_free ? S_P1_POP : S_P1_NEXT;
            S_P1_NEXT:  n_state = (r_v == '0) ? S_P2_FIN : S_P1_NODE;
            S_P1_POP:   n_state = (r_sp == '0) ? S_P1_NEXT : S_P1_POPW;
            S_P1_POPW: begin
                if (ws_rdata[NODE_W] || r_vis1[wcur]) begin
                    n_state = S_P1_POP;
                end else begin
                    n_state = S_P1_SCAN;
                end
            end
            S_P1_SCAN:  n_state = edges_done ? S_P1_POP : S_P1_SCANW;
            S_P1_SCANW: n_state = S_P1_SCAN;
            S_P2_FIN:   n_state = (r_fc == '0) ? S_O_READ : S_P2_FINW;
            S_P2_FINW:  n_state = r_asg[fs_rdata] ? S_P2_FIN : S_P2_POP;
            S_P2_POP: begin
                if (r_sp != '0) begin
                    n_state = S_P2_POPW;
                end else if (!r_minf && r_use_mask) begin
                    n_state = S_M_NODE;
                end else begin
                    n_state = S_P2_FIN;
                end
            end
            S_P2_POPW:  n_state = r_asg[wcur] ? S_P2_POP : S_P2_SCAN;
            S_P2_SCAN:  n_state = edges_done ? S_P2_POP : S_P2_SCANW;
            S_P2_SCANW: n_state = S_P2_SCAN;
            S_M_NODE: begin
                if (r_mv == r_n) begin
                    n_state = S_P2_FIN;
                end else if (r_asg[r_mv[NODE_W-1:0]]) begin
                    n_state = S_M_NODEW;
                end
            end
            S_M_NODEW:  n_state = (gs_rdata == r_gi) ? S_M_SCAN : S_M_NODE;
            S_M_SCAN:   n_state = edges_done ? S_P2_FIN : S_M_SCANW;
            S_M_SCANW:  n_state = pred_cand ? S_M_PREDW : S_M_SCAN;
            S_M_PREDW: begin
                if (!r_asg[r_f] || gs_rdata != r_gi) begin
                    n_state = S_M_NODE;
                end else begin
                    n_state = S_M_SCAN;
                end
            end
            S_O_READ:   n_state = (r_mv == r_n) ? S_IDLE : S_O_EMIT;
            S_O_EMIT:   n_state = S_O_READ;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_node_count = r_node_count;
        n_use_mask   = r_use_mask;
        n_n      = r_n;
        n_v      = r_v;
        n_mv     = r_mv;
        n_sp     = r_sp;
        n_fc     = r_fc;
        n_i      = r_i;
        n_cur    = r_cur;
        n_f      = r_f;
        n_gi     = r_gi;
        n_groups = r_groups;
        n_minf   = r_minf;
        n_ming   = r_ming;
        n_vis1   = r_vis1;
        n_asg    = r_asg;
        n_mask   = r_mask;
        n_ecnt   = r_ecnt;
        n_ovf    = r_ovf;
        n_res    = r_res;
        n_strobe = 1'b0;
        es_we = 1'b0; es_waddr = r_ecnt[EDGE_AW-1:0];
        es_wdata = {i_req.from_node, i_req.to_node};
        es_re = 1'b0; es_raddr = r_i[EDGE_AW-1:0];
        ws_we = 1'b0; ws_waddr = r_sp[WALK_AW-1:0]; ws_wdata = '0;
        ws_re = 1'b0; ws_raddr = WALK_AW'(r_sp - 1'b1);
        fs_we = 1'b0; fs_waddr = r_fc[FIN_AW-1:0]; fs_wdata = wcur;
        fs_re = 1'b0; fs_raddr = FIN_AW'(r_fc - 1'b1);
        gs_we = 1'b0; gs_waddr = r_cur; gs_wdata = r_gi;
        gs_re = 1'b0; gs_raddr = r_mv[NODE_W-1:0];

        if (cfg_wr) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                n_node_count = pwdata[CNT_W-1:0];
            end else begin
                n_use_mask = pwdata[0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.action)
                        ACT_ADD_EDGE: begin
                            if (r_ecnt < ECNT_W'(MAX_EDGES)) begin
                                es_we  = 1'b1;
                                n_ecnt = r_ecnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ACT_SET_ACTIVE: n_mask[i_req.from_node] = i_req.active_flag;
                        ACT_CLEAR: begin
                            n_ecnt = '0;
                            n_ovf  = 1'b0;
                        end
                        ACT_RUN: begin
                            n_n      = n_eff;
                            n_v      = NODE_W'(n_eff - 1'b1);
                            n_vis1   = '0;
                            n_asg    = '0;
                            n_fc     = '0;
                            n_groups = '0;
                            n_minf   = 1'b0;
                            n_ming   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_P1_NODE: begin
                if (v_free) begin
                    ws_we    = 1'b1;
                    ws_waddr = '0;
                    ws_wdata = {1'b0, r_v};
                    n_sp     = WSP_W'(1);
                end
            end
            S_P1_NEXT: n_v = r_v - 1'b1;
            S_P1_POP, S_P2_POP: begin
                if (r_sp != '0) begin
                    ws_re = 1'b1;
                    n_sp  = r_sp - 1'b1;
                end else if (r_state == S_P2_POP) begin
                    n_mv = '0;
                end
            end
            S_P1_POPW: begin
                n_i   = '0;
                n_cur = wcur;
                if (ws_rdata[NODE_W]) begin
                    // finished node: record it in the finishing order
                    if (r_fc < CNT_W'(MAX_NODES)) begin
                        fs_we = 1'b1;
                        n_fc  = r_fc + 1'b1;
                    end
                end else if (!r_vis1[wcur]) begin
                    n_vis1[wcur] = 1'b1;
                    if (ws_room) begin
                        ws_we    = 1'b1;
                        ws_wdata = {1'b1, wcur};
                        n_sp     = r_sp + 1'b1;
                    end
                end
            end
            S_P1_SCAN, S_P2_SCAN, S_M_SCAN: begin
                if (!edges_done) begin
                    es_re = 1'b1;
                end else if (r_state == S_M_SCAN) begin
                    n_minf = 1'b1;
                    n_ming = r_gi;
                end
            end
            S_P1_SCANW: begin
                n_i = r_i + 1'b1;
                if (hit1) begin
                    ws_we    = 1'b1;
                    ws_wdata = {1'b0, et};
                    n_sp     = r_sp + 1'b1;
                end
            end
            S_P2_FIN: begin
                if (r_fc != '0) begin
                    fs_re = 1'b1;
                    n_fc  = r_fc - 1'b1;
                end else begin
                    n_mv = '0;
                end
            end
            S_P2_FINW: begin
                if (!r_asg[fs_rdata]) begin
                    // open a new group
                    ws_we    = 1'b1;
                    ws_waddr = '0;
                    ws_wdata = {1'b0, fs_rdata};
                    n_sp     = WSP_W'(1);
                    n_gi     = r_groups[NODE_W-1:0];
                    n_groups = r_groups + 1'b1;
                end
            end
            S_P2_POPW: begin
                n_i   = '0;
                n_cur = wcur;
                if (!r_asg[wcur]) begin
                    n_asg[wcur] = 1'b1;
                    gs_we       = 1'b1;
                    gs_waddr    = wcur;
                end
            end
            S_P2_SCANW: begin
                n_i = r_i + 1'b1;
                if (hit2) begin
                    ws_we    = 1'b1;
                    ws_wdata = {1'b0, ef};
                    n_sp     = r_sp + 1'b1;
                end
            end
            S_M_NODE: begin
                if (r_mv != r_n) begin
                    if (r_asg[r_mv[NODE_W-1:0]]) begin
                        gs_re = 1'b1;
                    end else begin
                        n_mv = r_mv + 1'b1;
                    end
                end
            end
            S_M_NODEW: begin
                n_i = '0;
                if (gs_rdata != r_gi) begin
                    n_mv = r_mv + 1'b1;
                end
            end
            S_M_SCANW: begin
                n_f = ef;
                if (pred_cand) begin
                    gs_re    = 1'b1;
                    gs_raddr = ef;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_M_PREDW: begin
                if (!r_asg[r_f] || gs_rdata != r_gi) begin
                    // predecessor outside the group: try the next member
                    n_mv = r_mv + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_O_READ: begin
                if (r_mv != r_n) begin
                    gs_re = 1'b1;
                end
            end
            S_O_EMIT: begin
                n_strobe               = 1'b1;
                n_res.node_index       = r_mv[NODE_W-1:0];
                n_res.assigned         = r_asg[r_mv[NODE_W-1:0]];
                n_res.group_index      = r_asg[r_mv[NODE_W-1:0]] ? gs_rdata : '0;
                n_res.minimum_found    = r_minf;
                n_res.minimum_group    = r_minf ? r_ming : '0;
                n_res.edges_overflowed = r_ovf;
                n_res.last             = (CNT_W'(r_mv + 1'b1) == r_n);
                n_mv                   = r_mv + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= '0;
            r_use_mask   <= 1'b0;
            r_n          <= '0;
            r_v          <= '0;
            r_mv         <= '0;
            r_sp         <= '0;
            r_fc         <= '0;
            r_i          <= '0;
            r_groups     <= '0;
            r_minf       <= 1'b0;
            r_ming       <= '0;
            r_vis1       <= '0;
            r_asg        <= '0;
            r_mask       <= '0;
            r_ecnt       <= '0;
            r_ovf        <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_use_mask   <= n_use_mask;
            r_n          <= n_n;
            r_v          <= n_v;
            r_mv         <= n_mv;
            r_sp         <= n_sp;
            r_fc         <= n_fc;
            r_i          <= n_i;
            r_groups     <= n_groups;
            r_minf       <= n_minf;
            r_ming       <= n_ming;
            r_vis1       <= n_vis1;
            r_asg        <= n_asg;
            r_mask       <= n_mask;
            r_ecnt       <= n_ecnt;
            r_ovf        <= n_ovf;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_f   <= n_f;
        r_gi  <= n_gi;
        r_res <= n_res;
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    scg_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_edges (
        .i_clk(i_clk), .i_we(es_we), .i_waddr(es_waddr), .i_wdata(es_wdata),
        .i_re(es_re), .i_raddr(es_raddr), .o_rdata(es_rdata)
    );

    scg_ram #(.DEPTH(WALK_DEPTH), .WIDTH(WALK_W)) u_walk (
        .i_clk(i_clk), .i_we(ws_we), .i_waddr(ws_waddr), .i_wdata(ws_wdata),
        .i_re(ws_re), .i_raddr(ws_raddr), .o_rdata(ws_rdata)
    );

    scg_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_finish (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_re(fs_re), .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );

    scg_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_group (
        .i_clk(i_clk), .i_we(gs_we), .i_waddr(gs_waddr), .i_wdata(gs_wdata),
        .i_re(gs_re), .i_raddr(gs_raddr), .o_rdata(gs_rdata)
    );

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= WSP_W'(WALK_DEPTH))
        else $error("walk stack pointer beyond depth");

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= CNT_W'(MAX_NODES))
        else $error("finish count beyond node limit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |=> !o_res_strobe)
        else $error("result after last");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action == ACT_RUN && n_eff != '0) |=> busy)
        else $error("run did not start");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(r_state == S_O_EMIT))
        else $error("result strobe outside emit");
`endif

endmodule
